// File: hdl/lcfm_pkg.sv
// Package for the linear crossfade mixer: defaults, register codes, sequencer states, divider status.
`default_nettype none

package lcfm_pkg;

    // Default sizes
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int GAIN_FRAC_BITS_DEF = 14;
    localparam int MAX_CHANNELS_DEF   = 8;
    localparam int FRAME_BITS_DEF     = 16;

    // Gain is Q3.f: three integer bits plus sign above the fraction
    localparam int GAIN_INT_BITS  = 4;
    // Width of the channel count register
    localparam int CHANCOUNT_BITS = 4;
    // Width of the register index on the configuration port
    localparam int CFG_ADDR_BITS  = 3;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_DST_GAIN_START = 3'd0,
        REG_DST_GAIN_END   = 3'd1,
        REG_SRC_GAIN_START = 3'd2,
        REG_SRC_GAIN_END   = 3'd3,
        REG_FRAME_COUNT    = 3'd4,
        REG_CHANNEL_COUNT  = 3'd5
    } lcfm_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RAMP_MUL,
        ST_RAMP_START,
        ST_RAMP_WAIT,
        ST_RAMP_ADD,
        ST_MIX_DST,
        ST_MIX_SRC,
        ST_SUM,
        ST_OUT
    } lcfm_state_t;

    // Divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } lcfm_div_stat_t;

endpackage

`default_nettype wire

// File: hdl/lcfm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module lcfm_div #(
    parameter int DIVIDEND_BITS = 34,
    parameter int DIVISOR_BITS  = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [DIVIDEND_BITS-1:0] dividend,
    input  wire logic [DIVISOR_BITS-1:0]  divisor,
    output logic      [DIVIDEND_BITS-1:0] quotient,
    output lcfm_pkg::lcfm_div_stat_t      stat
);
    import lcfm_pkg::*;

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  dvs_reg;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;

    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    diff;
    logic                     take;

    assign trial = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign take  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(DIVIDEND_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], take};
            rem_reg <= take ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// File: hdl/linear_crossfade_mixer.sv
// Top level of the linear crossfade mixer: sequencer, shared multiplier, output register.
//
//  channel | direction | beat contents (low bits first)
//  s_axis  | in        | tdata: dst_sample, src_sample
//  m_axis  | out       | tdata: mixed_sample; tuser: clipped; tlast: last
//  cfg     | in        | wr_en, addr = register index, wdata = value
//
// Steps: a beat on channel zero of a frame first updates both gains with the bit-serial ramp
//   divider, run once per gain (ramp multiply, divide, add), then mixes like any other channel;
//   any other channel steps through mix dst, mix src, sum and output, using the single shared multiplier.
// One beat is in work at a time; s_axis_tready is high only when the sequencer is idle.
// A finished result waits in the output register; the next input beat is taken meanwhile,
//   and the sequencer stalls in its last step only if that register is still full.
// Reset (aresetn, synchronous, active low) restores register defaults and the frame position.
`default_nettype none

module linear_crossfade_mixer #(
    parameter int SAMPLE_BITS    = lcfm_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = lcfm_pkg::GAIN_FRAC_BITS_DEF,
    parameter int MAX_CHANNELS   = lcfm_pkg::MAX_CHANNELS_DEF,
    parameter int FRAME_BITS     = lcfm_pkg::FRAME_BITS_DEF,
    localparam int GAIN_BITS     = GAIN_FRAC_BITS + lcfm_pkg::GAIN_INT_BITS,
    localparam int CFG_DATA_BITS =
        (GAIN_BITS > FRAME_BITS) ? GAIN_BITS : FRAME_BITS,
    localparam int IN_DATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // slave side
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [IN_DATA_BITS-1:0]            s_axis_tdata,  // dst_sample, src_sample
    // master side
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic      [OUT_DATA_BITS-1:0]           m_axis_tdata,  // mixed_sample
    output logic                                    m_axis_tuser,  // clipped
    output logic                                    m_axis_tlast,
    // configuration writes
    input  wire logic                               cfg_wr_en,
    input  wire logic [lcfm_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0]           cfg_wdata
);
    import lcfm_pkg::*;

    // Multiplier operand widths: ramp is diff(G+1) x frame(F+1), mix is sample x gain
    localparam int MA = (SAMPLE_BITS > GAIN_BITS + 1) ? SAMPLE_BITS : GAIN_BITS + 1;
    localparam int MB = (GAIN_BITS > FRAME_BITS + 1) ? GAIN_BITS : FRAME_BITS + 1;
    localparam int PW = MA + MB;
    localparam int DIVIDEND_BITS = GAIN_BITS + FRAME_BITS;

    localparam int CI_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
    localparam int CHX_W = (CH_W > CHANCOUNT_BITS) ? CH_W : CHANCOUNT_BITS;

    localparam logic signed [PW:0] SAT_HI =
        {{(PW + 2 - SAMPLE_BITS){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [PW:0] SAT_LO =
        {{(PW + 2 - SAMPLE_BITS){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

    // Configuration registers
    logic signed [GAIN_BITS-1:0]  dst_start_reg, dst_end_reg;
    logic signed [GAIN_BITS-1:0]  src_start_reg, src_end_reg;
    logic [FRAME_BITS-1:0]        frame_count_reg;
    logic [CHANCOUNT_BITS-1:0]    chan_count_reg;

    // Frame position and current gains
    logic [FRAME_BITS-1:0]        frame_idx_reg;
    logic [CI_W-1:0]              chan_idx_reg;
    logic signed [GAIN_BITS-1:0]  dst_gain_reg, src_gain_reg;

    // Sequencer and datapath
    lcfm_state_t                  state_reg, state_next;
    logic                         ramp_src_reg;
    logic signed [SAMPLE_BITS-1:0] dst_smp_reg, src_smp_reg;
    logic signed [PW-1:0]         prod_reg;
    logic signed [PW:0]           sum_reg;
    logic                         neg_reg;

    // Output register
    logic                         m_valid_reg;
    logic [SAMPLE_BITS-1:0]       m_data_reg;
    logic                         m_clip_reg;
    logic                         m_last_reg;

    // Effective counts and indices; user keeps config steady while a beat is in work, not enforced
    logic [FRAME_BITS-1:0]        n_eff, n_last, fi_eff;
    logic [CHX_W-1:0]             ch_x, ch_last_x;
    logic [CI_W-1:0]              ch_last, ci_eff;
    logic                         last_ch, last_fr;

    always_comb begin
        n_eff     = (frame_count_reg == '0) ? FRAME_BITS'(1) : frame_count_reg;
        n_last    = n_eff - 1'b1;
        fi_eff    = (frame_idx_reg >= n_eff) ? n_last : frame_idx_reg;
        ch_x      = CHX_W'(chan_count_reg);
        if (ch_x == '0) begin
            ch_x = CHX_W'(1);
        end
        if (ch_x > CHX_W'(MAX_CHANNELS)) begin
            ch_x = CHX_W'(MAX_CHANNELS);
        end
        ch_last_x = ch_x - 1'b1;
        ch_last   = ch_last_x[CI_W-1:0];
        ci_eff    = (CHX_W'(chan_idx_reg) >= ch_x) ? ch_last : chan_idx_reg;
        last_ch   = (ci_eff == ch_last);
        last_fr   = (fi_eff == n_last);
    end

    // Ramp operands
    logic signed [GAIN_BITS-1:0]  ramp_start, ramp_end;
    logic signed [GAIN_BITS:0]    ramp_diff;

    assign ramp_start = ramp_src_reg ? src_start_reg : dst_start_reg;
    assign ramp_end   = ramp_src_reg ? src_end_reg   : dst_end_reg;
    assign ramp_diff  = (GAIN_BITS + 1)'(ramp_end) - (GAIN_BITS + 1)'(ramp_start);

    // Shared multiplier
    logic signed [MA-1:0] mul_a;
    logic signed [MB-1:0] mul_b;
    logic signed [PW-1:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_RAMP_MUL: begin
                mul_a = MA'(ramp_diff);
                mul_b = MB'($signed({1'b0, fi_eff}));
            end
            ST_MIX_DST: begin
                mul_a = MA'(dst_smp_reg);
                mul_b = MB'(dst_gain_reg);
            end
            ST_MIX_SRC: begin
                mul_a = MA'(src_smp_reg);
                mul_b = MB'(src_gain_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // Divider: |diff * i| / n, truncated toward zero
    logic signed [PW-1:0]         prod_mag;
    logic [DIVIDEND_BITS-1:0]     quotient;
    lcfm_div_stat_t               div_stat;
    logic                         div_start;
    logic signed [GAIN_BITS:0]    quo_s, ramp_sum;

    assign prod_mag  = prod_reg[PW-1] ? -prod_reg : prod_reg;
    assign div_start = (state_reg == ST_RAMP_START);

    lcfm_div #(
        .DIVIDEND_BITS(DIVIDEND_BITS),
        .DIVISOR_BITS (FRAME_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(prod_mag[DIVIDEND_BITS-1:0]),
        .divisor (n_eff),
        .quotient(quotient),
        .stat    (div_stat)
    );

    assign quo_s    = $signed({1'b0, quotient[GAIN_BITS-1:0]});
    assign ramp_sum = (GAIN_BITS + 1)'(ramp_start) + (neg_reg ? -quo_s : quo_s);

    // Floor shift and saturation
    logic signed [PW:0]           shifted;
    logic                         sat_hi, sat_lo;
    logic [SAMPLE_BITS-1:0]       res_data;

    assign shifted  = sum_reg >>> GAIN_FRAC_BITS;
    assign sat_hi   = (shifted > SAT_HI);
    assign sat_lo   = (shifted < SAT_LO);
    assign res_data = sat_hi ? SAT_HI[SAMPLE_BITS-1:0] :
                      sat_lo ? SAT_LO[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];

    logic out_free;
    logic s_accept;
    logic load_out;

    assign out_free = !m_valid_reg || m_axis_tready;
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign load_out = (state_reg == ST_OUT) && out_free;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = (ci_eff == '0) ? ST_RAMP_MUL : ST_MIX_DST;
                end
            end
            ST_RAMP_MUL:   state_next = ST_RAMP_START;
            ST_RAMP_START: state_next = ST_RAMP_WAIT;
            ST_RAMP_WAIT: begin
                if (div_stat.done) begin
                    state_next = ST_RAMP_ADD;
                end
            end
            ST_RAMP_ADD:   state_next = ramp_src_reg ? ST_MIX_DST : ST_RAMP_MUL;
            ST_MIX_DST:    state_next = ST_MIX_SRC;
            ST_MIX_SRC:    state_next = ST_SUM;
            ST_SUM:        state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dst_start_reg   <= GAIN_BITS'(1) << GAIN_FRAC_BITS;
            dst_end_reg     <= GAIN_BITS'(1) << GAIN_FRAC_BITS;
            src_start_reg   <= '0;
            src_end_reg     <= '0;
            frame_count_reg <= FRAME_BITS'(1);
            chan_count_reg  <= CHANCOUNT_BITS'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_DST_GAIN_START: dst_start_reg   <= cfg_wdata[GAIN_BITS-1:0];
                REG_DST_GAIN_END:   dst_end_reg     <= cfg_wdata[GAIN_BITS-1:0];
                REG_SRC_GAIN_START: src_start_reg   <= cfg_wdata[GAIN_BITS-1:0];
                REG_SRC_GAIN_END:   src_end_reg     <= cfg_wdata[GAIN_BITS-1:0];
                REG_FRAME_COUNT:    frame_count_reg <= cfg_wdata[FRAME_BITS-1:0];
                REG_CHANNEL_COUNT:  chan_count_reg  <= cfg_wdata[CHANCOUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Position and gain state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_idx_reg <= '0;
            chan_idx_reg  <= '0;
            dst_gain_reg  <= GAIN_BITS'(1) << GAIN_FRAC_BITS;
            src_gain_reg  <= '0;
            ramp_src_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                ramp_src_reg <= 1'b0;
            end
            if (state_reg == ST_RAMP_ADD) begin
                if (ramp_src_reg) begin
                    src_gain_reg <= ramp_sum[GAIN_BITS-1:0];
                end else begin
                    dst_gain_reg <= ramp_sum[GAIN_BITS-1:0];
                    ramp_src_reg <= 1'b1;
                end
            end
            if (load_out) begin
                if (last_ch) begin
                    chan_idx_reg  <= '0;
                    frame_idx_reg <= last_fr ? '0 : fi_eff + 1'b1;
                end else begin
                    chan_idx_reg  <= ci_eff + 1'b1;
                end
            end
        end
    end

    // Datapath payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            dst_smp_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
            src_smp_reg <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
        if (state_reg == ST_RAMP_MUL || state_reg == ST_MIX_DST
            || state_reg == ST_MIX_SRC) begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_RAMP_START) begin
            neg_reg <= prod_reg[PW-1];
        end
        if (state_reg == ST_MIX_SRC) begin
            sum_reg <= (PW + 1)'(prod_reg);
        end
        if (state_reg == ST_SUM) begin
            sum_reg <= sum_reg + (PW + 1)'(prod_reg);
        end
        if (load_out) begin
            m_data_reg <= res_data;
            m_clip_reg <= sat_hi || sat_lo;
            m_last_reg <= last_ch && last_fr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_DATA_BITS'(m_data_reg);
    assign m_axis_tuser  = m_clip_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

`default_nettype wire

// File: hdl/lcfm_chk.sv
// Port-level checker for the linear crossfade mixer, bound to the top level.
`default_nettype none

module lcfm_chk #(
    parameter int SAMPLE_BITS   = lcfm_pkg::SAMPLE_BITS_DEF,
    parameter int OUT_DATA_BITS = 24
) (
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_axis_tvalid,
    input wire logic                     s_axis_tready,
    input wire logic                     m_axis_tvalid,
    input wire logic                     m_axis_tready,
    input wire logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    input wire logic                     m_axis_tuser
);
    import lcfm_pkg::*;

    localparam logic [SAMPLE_BITS-1:0] MAX_S = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] MIN_S = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat withdrawn while stalled");

    // one beat in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a beat is in work");

    // a stalled result beat keeps its contents
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // a clipped sample sits at a rail
    a_clip_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[SAMPLE_BITS-1:0] == MAX_S)
            || (m_axis_tdata[SAMPLE_BITS-1:0] == MIN_S))
        else $error("clipped flag on an unsaturated sample");

endmodule

bind linear_crossfade_mixer lcfm_chk #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .OUT_DATA_BITS(OUT_DATA_BITS)
) u_lcfm_chk (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the linear crossfade mixer: directed table, then random settings phases.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lcfm_pkg::*;

    // Sizes follow the block's defaults
    localparam int SAMPLE_W   = SAMPLE_BITS_DEF;
    localparam int FRAC_W     = GAIN_FRAC_BITS_DEF;
    localparam int GAIN_W     = FRAC_W + GAIN_INT_BITS;
    localparam int FRAME_W    = FRAME_BITS_DEF;
    localparam int CHAN_MAX   = MAX_CHANNELS_DEF;
    localparam int CFG_W      = (GAIN_W > FRAME_W) ? GAIN_W : FRAME_W;
    localparam int IN_W       = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_W      = ((SAMPLE_W + 7) / 8) * 8;

    localparam int GAIN_MAX   = (1 << (GAIN_W - 1)) - 1;
    localparam int GAIN_MIN   = -(1 << (GAIN_W - 1));
    localparam int UNITY      = 1 << FRAC_W;
    localparam int SAMPLE_MAX = (1 << (SAMPLE_W - 1)) - 1;
    localparam int SAMPLE_MIN = -(1 << (SAMPLE_W - 1));
    localparam int FRAME_MAX  = (1 << FRAME_W) - 1;

    localparam real HALF_PERIOD = 5.0;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_BEATS = 550;
    localparam int HOLD_OFF     = 400;   // long receiver stall, fills the block
    localparam int STALL_LIMIT  = 3000;  // cycles with no beat moving before giving up
    localparam int DRAIN_CYCLES = 200;   // a stray result would show up in here

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [GAIN_W-1:0]   gain_t;

    typedef struct packed {
        sample_t mixed;
        logic    clipped;
        logic    last;
    } mix_result_t;

    typedef enum logic [1:0] {
        ROW_WRITE,   // register write, waits for the block to drain first
        ROW_MIX,     // beat checked against the predictor
        ROW_KNOWN    // beat with its result typed in
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        lcfm_reg_t   addr;
        int          value;
        int          dst;
        int          src;
        mix_result_t want;
    } plan_row_t;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_W-1:0]        s_axis_tdata  = '0;  // dst_sample, src_sample
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_W-1:0]       m_axis_tdata;        // mixed_sample
    logic                   m_axis_tuser;        // clipped
    logic                   m_axis_tlast;
    logic                   cfg_wr_en     = 1'b0;
    lcfm_reg_t              cfg_addr      = REG_DST_GAIN_START;
    logic [CFG_W-1:0]       cfg_wdata     = '0;

    // Predictor copy of the registers and the frame position, at their reset values
    gain_t                  dst_start_q = gain_t'(UNITY);
    gain_t                  dst_end_q   = gain_t'(UNITY);
    gain_t                  src_start_q = '0;
    gain_t                  src_end_q   = '0;
    logic [FRAME_W-1:0]     frames_q    = FRAME_W'(1);
    logic [CHANCOUNT_BITS-1:0] chans_q  = CHANCOUNT_BITS'(1);
    int unsigned            frame_pos   = 0;
    int unsigned            chan_pos    = 0;
    longint                 dst_gain_now = UNITY;
    longint                 src_gain_now = 0;

    mix_result_t            mix_due[$];   // results still owed by the block, oldest first

    int beats_sent   = 0;
    int results_seen = 0;
    int clip_count   = 0;
    int buffer_ends  = 0;
    int errors       = 0;
    int phases       = 0;

    always #(HALF_PERIOD) aclk = ~aclk;

    linear_crossfade_mixer u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Linear ramp point: start + (end - start) * pos / span, truncated towards zero
    function automatic longint ramp_point(gain_t g0, gain_t g1, int unsigned pos,
                                          int unsigned span);
        longint a, b, p, n;
        a = g0;
        b = g1;
        p = pos;
        n = span;
        return a + ((b - a) * p) / n;
    endfunction

    // One beat through the mixer; advances the frame position
    function automatic mix_result_t mix_predict(sample_t d, sample_t s);
        int unsigned span, width, fi, ci;
        longint      acc;
        mix_result_t r;
        // zero counts behave as one, channel count saturates at the maximum
        span  = (frames_q == 0) ? 1 : frames_q;
        width = (chans_q == 0) ? 1 : chans_q;
        if (width > CHAN_MAX) width = CHAN_MAX;
        // a count lowered under the current position pins it to the last slot
        fi = (frame_pos >= span) ? span - 1 : frame_pos;
        ci = (chan_pos >= width) ? width - 1 : chan_pos;
        // gains only move on the first channel of a frame
        if (ci == 0) begin
            dst_gain_now = ramp_point(dst_start_q, dst_end_q, fi, span);
            src_gain_now = ramp_point(src_start_q, src_end_q, fi, span);
        end
        acc = (longint'(d) * dst_gain_now + longint'(s) * src_gain_now) >>> FRAC_W;
        r.clipped = 1'b0;
        if (acc > SAMPLE_MAX) begin
            acc       = SAMPLE_MAX;
            r.clipped = 1'b1;
        end else if (acc < SAMPLE_MIN) begin
            acc       = SAMPLE_MIN;
            r.clipped = 1'b1;
        end
        r.mixed = acc[SAMPLE_W-1:0];
        r.last  = (ci == width - 1) && (fi == span - 1);
        if (ci == width - 1) begin
            chan_pos  = 0;
            frame_pos = (fi == span - 1) ? 0 : fi + 1;
        end else begin
            chan_pos = ci + 1;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------

    function automatic plan_row_t row_write(lcfm_reg_t addr, int value);
        plan_row_t r;
        r       = '{kind: ROW_WRITE, addr: addr, value: value, dst: 0, src: 0, want: '0};
        return r;
    endfunction

    function automatic plan_row_t row_mix(int d, int s);
        plan_row_t r;
        r       = '{kind: ROW_MIX, addr: REG_DST_GAIN_START, value: 0, dst: d, src: s,
                    want: '0};
        return r;
    endfunction

    function automatic plan_row_t row_known(int d, int s, int m, bit c, bit l);
        plan_row_t r;
        r              = row_mix(d, s);
        r.kind         = ROW_KNOWN;
        r.want.mixed   = m[SAMPLE_W-1:0];
        r.want.clipped = c;
        r.want.last    = l;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random picks
    // ------------------------------------------------------------------

    function automatic int pick_setting(lcfm_reg_t addr);
        case (addr)
            REG_FRAME_COUNT: begin
                case ($urandom_range(9))
                    0:       return 0;
                    1:       return FRAME_MAX;
                    2:       return $urandom_range(FRAME_MAX);
                    default: return $urandom_range(1, 6);
                endcase
            end
            REG_CHANNEL_COUNT: begin
                if ($urandom_range(3) == 0) return $urandom_range((1 << CHANCOUNT_BITS) - 1);
                return $urandom_range(1, CHAN_MAX);
            end
            default: begin
                case ($urandom_range(7))
                    0:       return GAIN_MAX;
                    1:       return GAIN_MIN;
                    2:       return UNITY;
                    3:       return 0;
                    4:       return -UNITY;
                    5:       return int'($urandom_range(2 * UNITY)) - UNITY;
                    default: return int'($urandom_range(GAIN_MAX - GAIN_MIN)) + GAIN_MIN;
                endcase
            end
        endcase
    endfunction

    // mode 0: any value, 1: edges of the range, 2: small enough to rarely clip
    function automatic sample_t pick_sample(int mode);
        case (mode)
            0: return sample_t'($urandom);
            1: begin
                case ($urandom_range(4))
                    0:       return sample_t'(SAMPLE_MAX);
                    1:       return sample_t'(SAMPLE_MIN);
                    2:       return sample_t'(1);
                    3:       return sample_t'(-1);
                    default: return '0;
                endcase
            end
            default: return sample_t'(int'($urandom_range(8191)) - 4096);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Drop valid and wait for every owed result; one result per beat, so empty means idle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (mix_due.size() != 0);
    endtask

    task automatic write_reg(lcfm_reg_t addr, int value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= CFG_W'(value);
        case (addr)
            REG_DST_GAIN_START: dst_start_q = gain_t'(value);
            REG_DST_GAIN_END:   dst_end_q   = gain_t'(value);
            REG_SRC_GAIN_START: src_start_q = gain_t'(value);
            REG_SRC_GAIN_END:   src_end_q   = gain_t'(value);
            REG_FRAME_COUNT:    frames_q    = FRAME_W'(value);
            REG_CHANNEL_COUNT:  chans_q     = CHANCOUNT_BITS'(value);
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Offer one beat; returns at the edge that took it, valid left high
    task automatic send_beat(sample_t d, sample_t s, bit typed, mix_result_t want);
        mix_result_t predicted;
        int          gap;
        predicted = mix_predict(d, s);
        mix_due.push_back(typed ? want : predicted);
        // a stretch of beats goes out back to back
        gap = 0;
        if (!(beats_sent >= 150 && beats_sent < 250) && $urandom_range(99) < 25)
            gap = $urandom_range(1, 6);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({s, d});
        do @(posedge aclk); while (!s_axis_tready);
        beats_sent++;
    endtask

    // ------------------------------------------------------------------
    // Result side: check each beat, then decide next cycle's ready
    // ------------------------------------------------------------------

    initial begin : result_side
        mix_result_t got, want;
        int          hold;
        bit          held_once;
        hold      = 0;
        held_once = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                got.mixed   = m_axis_tdata[SAMPLE_W-1:0];
                got.clipped = m_axis_tuser;
                got.last    = m_axis_tlast;
                results_seen++;
                clip_count  += got.clipped;
                buffer_ends += got.last;
                if (mix_due.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with none expected, got mixed %0d clip %0b last %0b",
                             $time, $signed(got.mixed), got.clipped, got.last);
                end else begin
                    want = mix_due.pop_front();
                    if (got.mixed !== want.mixed) begin
                        errors++;
                        $display("%0t: mixed_sample expected %0d, got %0d",
                                 $time, $signed(want.mixed), $signed(got.mixed));
                    end
                    if (got.clipped !== want.clipped) begin
                        errors++;
                        $display("%0t: clipped expected %0b, got %0b",
                                 $time, want.clipped, got.clipped);
                    end
                    if (got.last !== want.last) begin
                        errors++;
                        $display("%0t: last expected %0b, got %0b",
                                 $time, want.last, got.last);
                    end
                end
            end
            // one long hold-off mid-run, started while a beat is waiting at the input
            if (!held_once && results_seen >= 260 && s_axis_tvalid && !s_axis_tready) begin
                held_once = 1'b1;
                hold      = HOLD_OFF;
            end
            if (hold != 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if (results_seen >= 100 && results_seen < 200) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= 25);
            end
        end
    end

    // Watchdog: nothing moving for too long means the block has hung
    always @(posedge aclk) begin : watchdog
        int quiet;
        if (!aresetn || cfg_wr_en || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, mix_due.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin : stimulus
        plan_row_t   plan[$];
        int          directed_beats, phase_len, buffer, width, mode;
        mix_result_t none;
        none = '0;

        // After reset: unity on dst, nothing from src, one-sample buffers
        plan.push_back(row_known(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 0, 1));
        plan.push_back(row_known(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 0, 1));
        plan.push_back(row_known(0, SAMPLE_MAX, 0, 0, 1));
        // Gain extremes: saturation both ways, floor rounding of negatives
        plan.push_back(row_write(REG_DST_GAIN_START, GAIN_MAX));
        plan.push_back(row_write(REG_DST_GAIN_END, GAIN_MAX));
        plan.push_back(row_write(REG_SRC_GAIN_START, GAIN_MIN));
        plan.push_back(row_write(REG_SRC_GAIN_END, GAIN_MIN));
        plan.push_back(row_known(SAMPLE_MAX, 0, SAMPLE_MAX, 1, 1));
        plan.push_back(row_known(SAMPLE_MIN, 0, SAMPLE_MIN, 1, 1));
        plan.push_back(row_known(0, SAMPLE_MIN, SAMPLE_MAX, 1, 1));
        plan.push_back(row_known(0, SAMPLE_MAX, SAMPLE_MIN, 1, 1));
        plan.push_back(row_mix(1, 0));
        plan.push_back(row_mix(-1, 0));
        plan.push_back(row_mix(SAMPLE_MAX, SAMPLE_MAX));
        // All gains zero
        plan.push_back(row_write(REG_DST_GAIN_START, 0));
        plan.push_back(row_write(REG_DST_GAIN_END, 0));
        plan.push_back(row_write(REG_SRC_GAIN_START, 0));
        plan.push_back(row_write(REG_SRC_GAIN_END, 0));
        plan.push_back(row_known(SAMPLE_MIN, SAMPLE_MIN, 0, 0, 1));
        // Fade dst out, src in; zero frame and channel counts act as one
        plan.push_back(row_write(REG_DST_GAIN_START, UNITY));
        plan.push_back(row_write(REG_SRC_GAIN_END, UNITY));
        plan.push_back(row_write(REG_FRAME_COUNT, 0));
        plan.push_back(row_write(REG_CHANNEL_COUNT, 0));
        plan.push_back(row_known(1234567, -7654321, 1234567, 0, 1));
        // Channel count over the maximum saturates; three-frame ramp
        plan.push_back(row_write(REG_CHANNEL_COUNT, (1 << CHANCOUNT_BITS) - 1));
        plan.push_back(row_write(REG_FRAME_COUNT, 3));
        plan.push_back(row_mix(4000000, -3000000));
        plan.push_back(row_mix(-4000000, 3000000));
        plan.push_back(row_mix(SAMPLE_MAX, SAMPLE_MAX));
        plan.push_back(row_mix(SAMPLE_MIN, SAMPLE_MIN));
        plan.push_back(row_mix(777, -777));
        // Mid-frame: channel count cut under the position, gain moved (next frame only)
        plan.push_back(row_write(REG_CHANNEL_COUNT, 2));
        plan.push_back(row_write(REG_SRC_GAIN_START, -UNITY));
        plan.push_back(row_mix(2000000, 2000000));
        // Mid-buffer: frame count cut under the position, frame taken as the last
        plan.push_back(row_write(REG_FRAME_COUNT, 1));
        plan.push_back(row_mix(-2000000, 5000000));
        plan.push_back(row_mix(6000000, -6000000));
        // Longest buffer, opposite dst extreme
        plan.push_back(row_write(REG_FRAME_COUNT, FRAME_MAX));
        plan.push_back(row_write(REG_CHANNEL_COUNT, 1));
        plan.push_back(row_write(REG_DST_GAIN_END, GAIN_MIN));
        plan.push_back(row_mix(SAMPLE_MAX, SAMPLE_MIN));
        plan.push_back(row_mix(SAMPLE_MIN, SAMPLE_MAX));

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_WRITE: begin
                    wait_idle();
                    write_reg(plan[i].addr, plan[i].value);
                end
                ROW_MIX:
                    send_beat(sample_t'(plan[i].dst), sample_t'(plan[i].src), 1'b0, none);
                default:
                    send_beat(sample_t'(plan[i].dst), sample_t'(plan[i].src), 1'b1,
                              plan[i].want);
            endcase
        end
        directed_beats = beats_sent;

        // Random phases: drain, rewrite some registers, then a batch of beats.
        // Batches are often whole buffers, sometimes a ragged piece so the next
        // settings land mid-frame or mid-buffer.
        while (beats_sent < directed_beats + RANDOM_BEATS) begin
            wait_idle();
            phases++;
            for (int k = REG_DST_GAIN_START; k <= REG_CHANNEL_COUNT; k++) begin
                if ($urandom_range(3) != 0)
                    write_reg(lcfm_reg_t'(k), pick_setting(lcfm_reg_t'(k)));
            end
            width  = (chans_q == 0) ? 1 : ((chans_q > CHAN_MAX) ? CHAN_MAX : chans_q);
            buffer = ((frames_q == 0) ? 1 : frames_q) * width;
            if (buffer <= 48 && $urandom_range(3) != 0)
                phase_len = buffer * $urandom_range(1, 48 / buffer);
            else
                phase_len = $urandom_range(1, 24);
            mode = $urandom_range(2);
            repeat (phase_len)
                send_beat(pick_sample(mode), pick_sample(mode), 1'b0, none);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d beats (%0d directed) across %0d random settings phases.",
                 beats_sent, directed_beats, phases);
        $display("Checked %0d results: %0d saturated, %0d buffer ends, %0d mismatches.",
                 results_seen, clip_count, buffer_ends, errors);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/lcfm_pkg.sv
hdl/lcfm_div.sv
hdl/linear_crossfade_mixer.sv
hdl/lcfm_chk.sv
tb/testbench.sv
